[hw/rtl/implicit_array_bst_assert.svh]
// Assertion macros shared by the implicit array tree RTL files.
// Relies on each including module having ports named clock and reset.
`ifndef IMPLICIT_ARRAY_BST_ASSERT_SVH
`define IMPLICIT_ARRAY_BST_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IBST_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IBST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/ibst_pkg.sv]
// Shared constants and control/status types for the implicit array tree.
// No dependencies; used by ibst_ctrl, ibst_dp and implicit_array_bst.
package ibst_pkg;

   localparam int KEY_W          = 32;
   localparam int HEIGHT_W       = 4;
   localparam int LEVELS_DEFAULT = 10;

   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 4'd15;

   // Request codes on req_type.
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;    // new transaction taken this cycle
      logic clear_en;  // clearing pass writes one zero slot
      logic walk;      // evaluate the slot read for the current level
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic key_zero;   // the offered key is the empty-slot marker
      logic walk_done;  // the walk ends at the current level
      logic clear_last; // the clearing pass is at its final slot
   } status_type;

endpackage

[hw/rtl/ibst_ctrl.sv]
// Controller state machine for the implicit array tree.
// Depends on ibst_pkg and implicit_array_bst_assert.svh.
`include "implicit_array_bst_assert.svh"

module ibst_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  ibst_pkg::status_type st,
   output ibst_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_valid
);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_WALK  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (st.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               if (st.key_zero) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (st.walk_done) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `IBST_ASSERT_IMPL(a_rsp_in_idle, rsp_valid_ff, state_ff == ST_IDLE, "response outside idle")
   `IBST_ASSERT_NEXT(a_walk_end, (state_ff == ST_WALK) && st.walk_done,
                     rsp_valid_ff && (state_ff == ST_IDLE), "walk ended without response")
   `IBST_ASSERT_IMPL(a_clear_quiet, state_ff == ST_CLEAR, busy && !rsp_valid_ff,
                     "activity during clearing pass")

endmodule

[hw/rtl/ibst_dp.sv]
// Datapath for the implicit array tree: node memory, walk index, key compare,
// height tracking and result registers. Depends on ibst_pkg.
module ibst_dp #(
   parameter int LEVELS = ibst_pkg::LEVELS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ibst_pkg::cmd_type                 cmd,
   input  logic                              req_type,
   input  logic signed [ibst_pkg::KEY_W-1:0] req_key,
   output ibst_pkg::status_type              st,
   output logic                              rsp_found,
   output logic                              rsp_inserted,
   output logic                              rsp_overflow,
   output logic                              rsp_rejected,
   output logic [ibst_pkg::HEIGHT_W-1:0]     rsp_tree_height
);

   localparam int SLOTS   = 2 ** LEVELS;
   localparam int DEPTH_W = $clog2(LEVELS + 1);
   localparam int CMP_W   = (DEPTH_W > ibst_pkg::HEIGHT_W) ? DEPTH_W : ibst_pkg::HEIGHT_W;

   logic [ibst_pkg::KEY_W-1:0] mem [SLOTS];

   logic [ibst_pkg::KEY_W-1:0]  rd_data_ff;
   logic [LEVELS-1:0]           rd_addr;
   logic [LEVELS-1:0]           wr_addr;
   logic [ibst_pkg::KEY_W-1:0]  wr_data;
   logic                        wr_en;

   logic [LEVELS-1:0]           clr_cnt_ff, clr_cnt_in;
   logic [LEVELS-1:0]           idx_ff, idx_in;
   logic [DEPTH_W-1:0]          depth_ff, depth_in;
   logic [ibst_pkg::HEIGHT_W-1:0] height_ff, height_in;
   logic [ibst_pkg::KEY_W-1:0]  key_ff, key_in;
   logic                        type_ff, type_in;

   logic found_ff, found_in, inserted_ff, inserted_in;
   logic overflow_ff, overflow_in, rejected_ff, rejected_in;

   logic                        slot_empty, key_hit, go_left, last_level, do_insert;
   logic [LEVELS-1:0]           next_idx;
   logic [CMP_W-1:0]            depth_ext;
   logic [ibst_pkg::HEIGHT_W-1:0] depth_sat;

   // Walk evaluation on the slot read for the current level.
   assign slot_empty = (rd_data_ff == '0);
   assign key_hit    = (rd_data_ff == key_ff);
   assign go_left    = ($signed(key_ff) < $signed(rd_data_ff));
   assign last_level = idx_ff[LEVELS-1];
   assign next_idx   = {idx_ff[LEVELS-2:0], !go_left};
   assign do_insert  = cmd.walk && slot_empty && (type_ff == ibst_pkg::REQ_INSERT);

   assign depth_ext = CMP_W'(depth_ff);
   assign depth_sat = (depth_ext > CMP_W'(ibst_pkg::HEIGHT_MAX)) ? ibst_pkg::HEIGHT_MAX
                                                                : ibst_pkg::HEIGHT_W'(depth_ext);

   assign st.key_zero   = (req_key == '0);
   assign st.walk_done  = slot_empty || key_hit || last_level;
   assign st.clear_last = &clr_cnt_ff;

   assign rd_addr = cmd.accept ? LEVELS'(1) : next_idx;
   assign wr_en   = cmd.clear_en || do_insert;
   assign wr_addr = cmd.clear_en ? clr_cnt_ff : idx_ff;
   assign wr_data = cmd.clear_en ? '0 : key_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      clr_cnt_in  = cmd.clear_en ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      idx_in      = idx_ff;
      depth_in    = depth_ff;
      key_in      = key_ff;
      type_in     = type_ff;
      height_in   = height_ff;
      found_in    = found_ff;
      inserted_in = inserted_ff;
      overflow_in = overflow_ff;
      rejected_in = rejected_ff;
      if (cmd.accept) begin
         idx_in   = LEVELS'(1);
         depth_in = DEPTH_W'(1);
         key_in   = req_key;
         type_in  = req_type;
         if (st.key_zero) begin
            found_in    = 1'b0;
            inserted_in = 1'b0;
            overflow_in = 1'b0;
            rejected_in = 1'b1;
         end
      end else if (cmd.walk) begin
         if (st.walk_done) begin
            found_in    = key_hit;
            inserted_in = do_insert;
            overflow_in = !slot_empty && !key_hit && (type_ff == ibst_pkg::REQ_INSERT);
            rejected_in = 1'b0;
            if (do_insert && (depth_sat > height_ff)) begin
               height_in = depth_sat;
            end
         end else begin
            idx_in   = next_idx;
            depth_in = depth_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         height_ff  <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         height_ff  <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      depth_ff    <= depth_in;
      key_ff      <= key_in;
      type_ff     <= type_in;
      found_ff    <= found_in;
      inserted_ff <= inserted_in;
      overflow_ff <= overflow_in;
      rejected_ff <= rejected_in;
   end

   assign rsp_found       = found_ff;
   assign rsp_inserted    = inserted_ff;
   assign rsp_overflow    = overflow_ff;
   assign rsp_rejected    = rejected_ff;
   assign rsp_tree_height = height_ff;

endmodule

[hw/rtl/implicit_array_bst.sv]
// Top level of the implicit array binary search tree.
// Depends on ibst_pkg, ibst_ctrl, ibst_dp and implicit_array_bst_assert.svh.
//
// A transaction is offered on req_type/req_key with start and is taken at a
// clock edge where start is high and busy is low. req_type selects an insert
// or a search; the key is a signed 32-bit value and zero is refused.
// Every transaction produces exactly one response, shown on the rsp_ ports
// for a single cycle while rsp_valid is high. The receiver cannot stall, so
// the response must be captured in that cycle.
// A zero key answers in the cycle after it is taken. Otherwise the walk
// reads one node memory slot per tree level, one level per cycle, down to
// at most level LEVELS, and the response is registered from the level at
// which the walk stops. An insert writes its slot in the final walk
// cycle. The single memory read port sets this pace; one transaction is in
// flight at a time, and busy drops in the cycle the response is shown, so
// the next transaction may be taken in that same cycle.
// After reset the block runs a clearing pass that writes zero to all
// 2^LEVELS slots, one per cycle, holding busy high throughout. The
// tree height register is cleared at reset.
`include "implicit_array_bst_assert.svh"

module implicit_array_bst #(
   parameter int LEVELS = ibst_pkg::LEVELS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_type,
   input  logic signed [ibst_pkg::KEY_W-1:0] req_key,
   output logic                              rsp_valid,
   output logic                              rsp_found,
   output logic                              rsp_inserted,
   output logic                              rsp_overflow,
   output logic                              rsp_rejected,
   output logic [ibst_pkg::HEIGHT_W-1:0]     rsp_tree_height
);

   ibst_pkg::cmd_type    cmd;
   ibst_pkg::status_type st;

   // The controller sequences the clearing pass and the level-by-level walk.
   ibst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .st        (st),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // The datapath holds the node memory, the walk index and the results.
   ibst_dp #(
      .LEVELS (LEVELS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_type        (req_type),
      .req_key         (req_key),
      .st              (st),
      .rsp_found       (rsp_found),
      .rsp_inserted    (rsp_inserted),
      .rsp_overflow    (rsp_overflow),
      .rsp_rejected    (rsp_rejected),
      .rsp_tree_height (rsp_tree_height)
   );

   // A response carries at most one of its outcome flags.
   `IBST_ASSERT_IMPL(a_rsp_outcome, rsp_valid,
                     $onehot0({rsp_found, rsp_inserted, rsp_overflow, rsp_rejected}),
                     "conflicting response flags")

endmodule
